[sv/tcw_pkg.sv]
package tcw_pkg;

  localparam int COLS_DEF     = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SCAN_INIT,
    SCAN_CLEAR,
    SCAN_SCROLL
  } scan_kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       scan_start;
    scan_kind_t scan_kind;
    logic       wr_en;
    logic       rd_en;
  } buf_req_t;

endpackage

[sv/tcw_buffer.sv]
module tcw_buffer import tcw_pkg::*; #(
  parameter int COLS   = COLS_DEF,
  parameter int ROWS   = ROWS_DEF,
  parameter int ADDR_W = $clog2(COLS * ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  buf_req_t          req,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [15:0]       blank,
  output logic [15:0]       rd_data,
  output logic              busy
);

  localparam int CELLS     = COLS * ROWS;
  localparam int LAST_BASE = CELLS - COLS;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data_r;
  logic              scan_act_r;
  logic              pipe_vld_r;
  logic [ADDR_W-1:0] scan_idx_r;
  logic [ADDR_W-1:0] pipe_idx_r;
  scan_kind_t        kind_r;

  logic [ADDR_W:0]   src_sum;
  logic [ADDR_W-1:0] mem_ra;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [15:0]       mem_wd;
  logic              mem_we;

  // scroll copies the cell one row below into the current one
  assign src_sum = {1'b0, scan_idx_r} + (ADDR_W+1)'(COLS);

  always_comb begin
    if (scan_act_r) begin
      mem_ra = (src_sum < (ADDR_W+1)'(CELLS)) ? src_sum[ADDR_W-1:0] : scan_idx_r;
      mem_re = (kind_r == SCAN_SCROLL);
    end else begin
      mem_ra = rd_addr;
      mem_re = req.rd_en;
    end
  end

  always_comb begin
    if (pipe_vld_r) begin
      mem_wa = pipe_idx_r;
      mem_we = 1'b1;
      case (kind_r)
        SCAN_INIT:   mem_wd = 16'h0000;
        SCAN_SCROLL: mem_wd = ({1'b0, pipe_idx_r} < (ADDR_W+1)'(LAST_BASE)) ? rd_data_r : blank;
        default:     mem_wd = blank;
      endcase
    end else begin
      mem_wa = wr_addr;
      mem_wd = wr_data;
      mem_we = req.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // reset starts a zero fill over the whole buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b1;
      kind_r     <= SCAN_INIT;
      scan_idx_r <= '0;
      pipe_vld_r <= 1'b0;
    end else begin
      pipe_vld_r <= scan_act_r;
      if (req.scan_start) begin
        scan_act_r <= 1'b1;
        kind_r     <= req.scan_kind;
        scan_idx_r <= '0;
      end else if (scan_act_r) begin
        if (scan_idx_r == ADDR_W'(CELLS - 1)) begin
          scan_act_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r <= scan_idx_r;
  end

  assign rd_data = rd_data_r;
  assign busy    = scan_act_r | pipe_vld_r;

  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !busy) else $error("cell write during buffer sweep");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.scan_start |-> !busy) else $error("sweep started while sweeping");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_act_r |-> 32'(scan_idx_r) < CELLS) else $error("sweep index out of range");

endmodule

[sv/text_console_writer_unit.sv]
// Character-cell text console: a ROWS x COLS buffer of 16-bit cells (attribute
// byte above character byte) with a cursor, all cells in one synchronous RAM.
// Input channel (in_valid / in_stall) takes one transaction: put a character,
// clear the screen, read one cell, or a no-op. Output channel (out_valid /
// out_stall) returns exactly one transaction per input: cursor after the item,
// a scroll flag and the read cell word (zero for all but an in-range read).
// A put without scroll passes through the put state and an in-range read
// through the read state before the done state; a no-op or an out-of-range
// read goes straight to done. Clear and scroll sweep the RAM one cell per
// cycle over the whole buffer in the sweep state. A new transaction can be
// accepted in the cycle after the result is handed to the output register, so
// a new item is taken only once the last one is done; the single RAM write
// port sets the sweep length.
// The output register holds the last result while out_stall is high; the
// next transaction still runs and waits in its final state for the register.
// Reset (synchronous, rst_n low) homes the cursor, sets the attribute to 0x0F
// and starts a zero fill of the RAM; in_stall stays high until it ends.
// cfg_wr_en/cfg_wr_data set the attribute byte and may be written at any
// idle time.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out,
  output logic        out_scrolled,
  output logic [15:0] out_cell_word
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int COLX_W = $clog2(COLS + TAB_STOP + 1);
  localparam int PH_W   = $clog2(TAB_STOP);
  localparam int CMP_W  = (ADDR_W > 11) ? ADDR_W + 1 : 12;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [PH_W-1:0]   ph_r;
  logic [7:0]        attr_r;
  logic [7:0]        char_r;
  logic              res_scrolled_r;
  logic [15:0]       res_word_r;
  logic              out_valid_r;
  logic [4:0]        out_row_r;
  logic [6:0]        out_col_r;
  logic              out_scrolled_r;
  logic [15:0]       out_word_r;

  logic              in_acc;
  func_t             func;
  logic              rd_ok;
  logic              out_load;
  buf_req_t          buf_req;
  logic              buf_busy;
  logic [15:0]       buf_rd_data;
  logic [ADDR_W-1:0] cell_idx;
  logic [ADDR_W-1:0] rd_idx;

  logic [ROWX_W-1:0] row_t;
  logic [COLX_W-1:0] col_t;
  logic [PH_W-1:0]   ph_t;
  logic              wr_cell;
  logic              scroll;

  assign in_acc   = in_valid && !in_stall;
  assign func     = func_t'(in_func);
  assign rd_ok    = CMP_W'(in_cell_address) < CMP_W'(CELLS);
  assign rd_idx   = ADDR_W'(in_cell_address);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign cell_idx = ADDR_W'(row_r) * ADDR_W'(COLS) + ADDR_W'(col_r);

  // cursor move for a put; ph tracks the column modulo the tab stop
  always_comb begin
    row_t   = ROWX_W'(row_r);
    col_t   = COLX_W'(col_r);
    ph_t    = ph_r;
    wr_cell = 1'b0;
    unique case (char_r)
      CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_t = COLX_W'(col_r) - 1'b1;
          ph_t  = (ph_r == '0) ? PH_W'(TAB_STOP - 1) : ph_r - 1'b1;
        end
      end
      CH_TAB: begin
        col_t = COLX_W'(col_r) + COLX_W'(TAB_STOP) - COLX_W'(ph_r);
        ph_t  = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = ROWX_W'(row_r) + 1'b1;
        ph_t  = '0;
      end
      CH_CR: begin
        col_t = '0;
        ph_t  = '0;
      end
      default: begin
        wr_cell = 1'b1;
        col_t   = COLX_W'(col_r) + 1'b1;
        ph_t    = (ph_r == PH_W'(TAB_STOP - 1)) ? '0 : ph_r + 1'b1;
      end
    endcase
    if (col_t >= COLX_W'(COLS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
      ph_t  = '0;
    end
    scroll = (row_t >= ROWX_W'(ROWS));
    if (scroll) begin
      row_t = ROWX_W'(ROWS - 1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (!buf_busy) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func)
            FUNC_PUT:   state_nxt = ST_PUT;
            FUNC_CLEAR: state_nxt = ST_SCAN;
            FUNC_READ:  state_nxt = rd_ok ? ST_READ : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PUT:  state_nxt = scroll ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (!buf_busy) state_nxt = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = (state_r != ST_IDLE);
    buf_req.scan_start = 1'b0;
    buf_req.scan_kind  = SCAN_CLEAR;
    buf_req.wr_en      = 1'b0;
    buf_req.rd_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        buf_req.scan_start = in_acc && (func == FUNC_CLEAR);
        buf_req.rd_en      = in_acc && (func == FUNC_READ) && rd_ok;
      end
      ST_PUT: begin
        buf_req.scan_start = scroll;
        buf_req.scan_kind  = SCAN_SCROLL;
        buf_req.wr_en      = wr_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      ph_r        <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (state_r == ST_PUT) begin
        row_r <= row_t[ROW_W-1:0];
        col_r <= col_t[COL_W-1:0];
        ph_r  <= ph_t;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_r         <= in_char_code;
      res_scrolled_r <= 1'b0;
      res_word_r     <= '0;
    end
    if (state_r == ST_PUT) begin
      res_scrolled_r <= scroll;
    end
    if (state_r == ST_READ) begin
      res_word_r <= buf_rd_data;
    end
    if (out_load) begin
      out_row_r      <= 5'(row_r);
      out_col_r      <= 7'(col_r);
      out_scrolled_r <= res_scrolled_r;
      out_word_r     <= res_word_r;
    end
  end

  tcw_buffer #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_buffer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (buf_req),
    .wr_addr (cell_idx),
    .wr_data ({attr_r, char_r}),
    .rd_addr (rd_idx),
    .blank   ({attr_r, CH_BLANK}),
    .rd_data (buf_rd_data),
    .busy    (buf_busy)
  );

  assign out_valid          = out_valid_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;
  assign out_scrolled       = out_scrolled_r;
  assign out_cell_word      = out_word_r;

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE) else $error("transaction lost");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLS) else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < ROWS) else $error("cursor row out of range");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    buf_busy |-> state_r == ST_INIT || state_r == ST_SCAN)
    else $error("buffer sweep outside sweep state");

  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(buf_req.rd_en)) else $error("read result without read");

endmodule

[tb/sv/text_console_writer_unit_test.sv]
`timescale 1ns / 100ps

module text_console_writer_unit_test import tcw_pkg::*;;

  localparam int CELLS = COLS_DEF * ROWS_DEF;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
    logic [15:0] word;
  } console_result_t;

  // mirrors the screen, cursor and attribute; holds results still to come
  class console_tracker;
    logic [15:0]     cells [CELLS];
    int unsigned     cur_row;
    int unsigned     cur_col;
    logic [7:0]      attribute;
    console_result_t awaited_results [$];
    int unsigned     errors;
    int unsigned     n_scrolls;
    int unsigned     n_clears;
    int unsigned     n_reads;
    int unsigned     n_items;

    function new();
      foreach (cells[i]) cells[i] = 16'h0000;
      cur_row = 0;
      cur_col = 0;
      attribute = ATTR_RESET;
      errors = 0;
      n_scrolls = 0;
      n_clears = 0;
      n_reads = 0;
      n_items = 0;
    endfunction

    function void set_attribute(logic [7:0] v);
      attribute = v;
    endfunction

    function int unsigned cursor_cell();
      return cur_row * COLS_DEF + cur_col;
    endfunction

    function int unsigned pending_count();
      return awaited_results.size();
    endfunction

    function void blank_from(int unsigned first);
      for (int unsigned i = first; i < CELLS; i++) cells[i] = {attribute, CH_BLANK};
    endfunction

    function bit wrap_and_scroll();
      if (cur_col >= COLS_DEF) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS_DEF) begin
        for (int unsigned i = 0; i < CELLS - COLS_DEF; i++) cells[i] = cells[i + COLS_DEF];
        blank_from(CELLS - COLS_DEF);
        cur_row = ROWS_DEF - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit put_glyph(logic [7:0] c);
      if (c == CH_BACKSPACE) begin
        if (cur_col > 0) cur_col--;
      end else if (c == CH_TAB) begin
        cur_col = (cur_col / TAB_STOP_DEF + 1) * TAB_STOP_DEF;
      end else if (c == CH_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (c == CH_CR) begin
        cur_col = 0;
      end else begin
        cells[cur_row * COLS_DEF + cur_col] = {attribute, c};
        cur_col++;
      end
      return wrap_and_scroll();
    endfunction

    function void note_transaction(func_t f, logic [7:0] c, logic [10:0] a);
      console_result_t r;
      r = '0;
      case (f)
        FUNC_PUT: begin
          r.scrolled = put_glyph(c);
          if (r.scrolled) n_scrolls++;
        end
        FUNC_CLEAR: begin
          blank_from(0);
          n_clears++;
        end
        FUNC_READ: begin
          if (a < CELLS) r.word = cells[a];
          n_reads++;
        end
        default: ;
      endcase
      r.row = cur_row[4:0];
      r.col = cur_col[6:0];
      awaited_results.push_back(r);
      n_items++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_transaction(console_result_t got);
      console_result_t exp;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing awaited: row %0d col %0d", got.row, got.col));
      end else begin
        exp = awaited_results.pop_front();
        if (got.row != exp.row)
          report($sformatf("cursor row %0d, awaited %0d", got.row, exp.row));
        if (got.col != exp.col)
          report($sformatf("cursor col %0d, awaited %0d", got.col, exp.col));
        if (got.scrolled != exp.scrolled)
          report($sformatf("scroll flag %0b, awaited %0b", got.scrolled, exp.scrolled));
        if (got.word != exp.word)
          report($sformatf("cell word %h, awaited %h", got.word, exp.word));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_address;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_cursor_row_out;
  logic [6:0]  out_cursor_col_out;
  logic        out_scrolled;
  logic [15:0] out_cell_word;

  console_tracker tracker = new();
  bit             calm = 1'b0;
  int unsigned    n_settings = 0;

  text_console_writer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_char_code       (in_char_code),
    .in_cell_address    (in_cell_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_scrolled       (out_scrolled),
    .out_cell_word      (out_cell_word)
  );

  always #10 clk = ~clk;

  // result side: check with the stall seen at this edge, then pick the next one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_transaction({out_cursor_row_out, out_cursor_col_out,
                                 out_scrolled, out_cell_word});
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  // valid stays high from one transaction to the next unless an idle cycle is picked
  task automatic send_item(input func_t f, input logic [7:0] c, input logic [10:0] a);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_char_code    <= c;
    in_cell_address <= a;
    do @(posedge clk); while (in_stall);
    tracker.note_transaction(f, c, a);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_attribute(v);
    n_settings++;
  endtask

  // reads often land near the cursor, where cells were just written
  function automatic logic [10:0] aimed_address();
    int unsigned pick;
    int unsigned spot;
    pick = $urandom_range(0, 99);
    spot = tracker.cursor_cell();
    if (pick < 40) return (spot >= 3) ? 11'(spot - $urandom_range(1, 3)) : 11'(spot);
    if (pick < 55) return 11'($urandom_range(CELLS - COLS_DEF, CELLS - 1));
    if (pick < 70) return 11'($urandom_range(CELLS, 2047));
    return 11'($urandom_range(0, CELLS - 1));
  endfunction

  task automatic random_item();
    int unsigned  pick;
    func_t        f;
    logic [7:0]   c;
    logic [10:0]  a;
    pick = $urandom_range(0, 999);
    f = FUNC_PUT;
    c = 8'($urandom_range(0, 255));
    a = 11'($urandom_range(0, 2047));
    if (pick < 5) f = FUNC_CLEAR;
    else if (pick < 25) f = FUNC_NOP;
    else if (pick < 145) begin
      f = FUNC_READ;
      a = aimed_address();
    end
    else if (pick < 185) c = CH_LF;
    else if (pick < 205) c = CH_CR;
    else if (pick < 245) c = CH_BACKSPACE;
    else if (pick < 295) c = CH_TAB;
    else if (pick < 750) c = 8'($urandom_range(8'h21, 8'h7E));
    send_item(f, c, a);
  endtask

  initial begin
    #1_000_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 8'h00;
    in_valid        <= 1'b0;
    in_func         <= FUNC_NOP;
    in_char_code    <= 8'h00;
    in_cell_address <= 11'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of each field, control characters, odd reads
    send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
    send_item(FUNC_PUT, 8'h41, 11'd0);
    send_item(FUNC_PUT, 8'hFF, 11'd0);
    send_item(FUNC_PUT, 8'h00, 11'd2047);
    send_item(FUNC_PUT, 8'h80, 11'd0);
    send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
    send_item(FUNC_PUT, CH_TAB, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'hFF, 11'd1);
    send_item(FUNC_READ, 8'h00, 11'd2);
    send_item(FUNC_READ, 8'h00, 11'd3);
    send_item(FUNC_READ, 8'h00, 11'd1999);
    send_item(FUNC_READ, 8'h00, 11'd2000);
    send_item(FUNC_READ, 8'h00, 11'd2047);
    send_item(FUNC_PUT, CH_CR, 11'd0);
    send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
    send_item(FUNC_PUT, CH_LF, 11'd0);
    send_item(FUNC_NOP, 8'hFF, 11'd2047);
    send_item(FUNC_CLEAR, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd80);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_attribute(8'hFF);
        1:       write_attribute(8'h00);
        default: write_attribute(8'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < 400; i++) begin
        // long stretch with both sides busy every cycle
        calm = (phase == 2) && (i < 250);
        random_item();
      end
    end
    calm = 1'b0;
    write_attribute(ATTR_RESET);
    for (int i = 0; i < 20; i++) random_item();

    drain();
    if (tracker.pending_count() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending_count()));
    $display("covered %0d transactions over %0d attribute settings", tracker.n_items, n_settings);
    $display("%0d scrolls, %0d clears, %0d cell reads", tracker.n_scrolls,
             tracker.n_clears, tracker.n_reads);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
